// ===== sv/sli_pkg.sv =====
// Shared types and constants for the sorted list store.
package sli_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int VAL_W    = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic update;     // apply the accepted request, load a single result
      logic dump_step;  // load the next stored value as a result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic dump_last;
   } path_stat_type;

endpackage

// ===== sv/sli_ctrl.sv =====
// Controller: request/result handshakes and dump sequencing.
module sli_ctrl
   import sli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_command,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  path_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;
   logic      start_dump;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign start_dump = (req_command == CMD_DUMP) && !stat.count_zero;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.update    = 1'b0;
      cmd.dump_step = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.update = !start_dump;
               if (start_dump) begin
                  state_in = S_DUMP;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               cmd.dump_step = 1'b1;
               rsp_valid_in  = 1'b1;
               if (stat.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/sli_path.sv =====
// Datapath: compare-and-shift cell chain, count, dump index and result register.
module sli_path
   import sli_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_command,
   input  logic signed [VAL_W-1:0] req_operand_value,
   input  ctrl_cmd_type            cmd,
   output path_stat_type           stat,
   output logic [1:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_element_value,
   output logic                    rsp_last,
   output logic [4:0]              rsp_element_count
);

   logic signed [VAL_W-1:0] cells_ff [CAPACITY];
   logic signed [VAL_W-1:0] cells_in [CAPACITY];
   logic signed [VAL_W-1:0] ins_val  [CAPACITY];
   logic signed [VAL_W-1:0] del_val  [CAPACITY];
   logic [CAPACITY-1:0]     le, lt, eq;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [1:0]              status_ff, status_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    last_ff, last_in;
   logic                    full;
   logic                    found;
   logic                    load_rsp;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic held;
      assign held  = CNT_W'(i) < count_ff;
      assign le[i] = held && (cells_ff[i] <= req_operand_value);
      assign lt[i] = held && (cells_ff[i] < req_operand_value);
      assign eq[i] = held && (cells_ff[i] == req_operand_value);
      if (i == 0) begin : g_first
         assign ins_val[i] = le[i] ? cells_ff[i] : req_operand_value;
      end else begin : g_rest
         assign ins_val[i] = le[i]     ? cells_ff[i]       :
                             le[i - 1] ? req_operand_value : cells_ff[i - 1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign del_val[i] = cells_ff[i];
      end else begin : g_mid
         assign del_val[i] = lt[i] ? cells_ff[i] : cells_ff[i + 1];
      end
   end

   assign full            = count_ff == CNT_W'(CAPACITY);
   assign found           = |eq;
   assign stat.count_zero = count_ff == '0;
   assign stat.dump_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      cells_in  = cells_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = STAT_OK;
      value_in  = '0;
      last_in   = 1'b1;
      load_rsp  = 1'b0;
      if (cmd.update) begin
         load_rsp = 1'b1;
         idx_in   = '0;
         case (req_command)
            CMD_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  cells_in = ins_val;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_DELETE: begin
               if (count_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else if (!found) begin
                  status_in = STAT_NOT_FOUND;
               end else begin
                  cells_in = del_val;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_DUMP: begin
               status_in = STAT_EMPTY;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end else if (cmd.dump_step) begin
         load_rsp = 1'b1;
         value_in = cells_ff[idx_ff];
         last_in  = stat.dump_last;
         // back to the head so a following dump starts at the first value
         if (stat.dump_last) begin
            idx_in = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (load_rsp) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         last_ff   <= last_in;
      end
   end

   logic [CNT_W-1:0] count_rsp_ff;

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         count_rsp_ff <= count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_element_value = value_ff;
   assign rsp_last          = last_ff;
   assign rsp_element_count = 5'(count_rsp_ff);

endmodule

// ===== sv/sorted_list_insert_delete.sv =====
// Sorted list store: top level joining controller and cell-chain datapath.
// Insert, delete and other single-result commands: result valid in the cycle after accept.
// Dump of N values: N results, one per cycle while rsp_ready holds, the first loaded in the dump state.
// A new request is taken once the previous result has been or is being taken, so one per
// cycle while rsp_ready holds; none during a dump.
// Synchronous active-high reset empties the store; cell contents are not cleared.
module sorted_list_insert_delete
   import sli_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_command,
   input  logic signed [VAL_W-1:0] req_operand_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_element_value,
   output logic                    rsp_last,
   output logic [4:0]              rsp_element_count
);

   ctrl_cmd_type  cmd;
   path_stat_type stat;

   sli_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   sli_path u_path (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_last          (rsp_last),
      .rsp_element_count (rsp_element_count)
   );

endmodule

// ===== sv/sli_check.sv =====
// Port-level checker for the sorted list store, bound to the top level.
module sli_check
   import sli_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              rsp_status,
   input logic signed [VAL_W-1:0] rsp_element_value,
   input logic                    rsp_last,
   input logic [4:0]              rsp_element_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_element_value) && $stable(rsp_last) && $stable(rsp_element_count))
      else $error("result beat changed while stalled");

   a_mid_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STAT_OK)
      else $error("non-final beat without ok status");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_element_count == 5'd0 && rsp_last)
      else $error("empty status with non-zero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_element_count == 5'(CAPACITY))
      else $error("full status below capacity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_list_insert_delete sli_check u_sli_check (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_element_value (rsp_element_value),
   .rsp_last          (rsp_last),
   .rsp_element_count (rsp_element_count)
);
